// ===== sv/pal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY_DEF   = 128;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_PRIOR  = 3'd4,
        CMD_NEXT   = 3'd5,
        CMD_CLEAR  = 3'd6
    } pal_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_BAD_POS = 2'd1,
        STS_FULL    = 2'd2,
        STS_MISS    = 2'd3
    } pal_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_KEY,
        ST_RESULT
    } pal_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic walk;
        logic put_key;
        logic emit;
    } pal_dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_req;
        logic key_req;
        logic walk_done;
        logic out_free;
    } pal_dp_sts_t;

endpackage

// ===== sv/pal_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pal_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl
// Command sequencer: accept, evaluate, walk the store, write the key, emit.
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output pal_pkg::pal_dp_cmd_t dp_cmd,
    input  pal_pkg::pal_dp_sts_t dp_sts
);

    import pal_pkg::*;

    pal_state_t state_reg;
    pal_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                dp_cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                dp_cmd.eval = 1'b1;
                if (dp_sts.walk_req)
                begin
                    state_next = ST_WALK;
                end
                else if (dp_sts.key_req)
                begin
                    state_next = ST_KEY;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WALK:
            begin
                dp_cmd.walk = 1'b1;
                if (dp_sts.walk_done)
                begin
                    state_next = dp_sts.key_req ? ST_KEY : ST_RESULT;
                end
            end
            ST_KEY:
            begin
                dp_cmd.put_key = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (dp_sts.out_free)
                begin
                    dp_cmd.emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pal_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: entry store, length, walk pointers, match logic, result register.
// ----------------------------------------------------------------------------
module pal_dp #(
    parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pal_pkg::pal_dp_cmd_t                dp_cmd,
    output pal_pkg::pal_dp_sts_t                dp_sts,
    input  logic [pal_pkg::CMD_W-1:0]           command,
    input  logic [pal_pkg::POS_W-1:0]           position,
    input  logic signed [pal_pkg::VAL_W-1:0]    value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pal_pkg::STATUS_W-1:0]        status,
    output logic signed [pal_pkg::VAL_W-1:0]    data_out,
    output logic [pal_pkg::POS_W-1:0]           found_position,
    output logic [pal_pkg::POS_W-1:0]           count,
    output logic                                is_empty
);

    import pal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    // request registers
    pal_cmd_t            cmd_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_WIDTH-1:0] key_reg;

    logic [CW-1:0]       count_reg,   count_next;

    // walk state
    logic [AW-1:0]       rd_ptr_reg,  rd_ptr_next;
    logic [CW-1:0]       rd_left_reg, rd_left_next;
    logic                rsp_vld_reg, rsp_vld_next;
    logic [AW-1:0]       rsp_addr_reg;
    logic                rsp_first_reg, rsp_first_next;
    logic                hit_reg,       hit_next;
    logic                take_next_reg, take_next_next;
    logic [DATA_WIDTH-1:0] prev_data_reg;

    // working result
    pal_status_t         res_status_reg, res_status_next;
    logic signed [VAL_W-1:0] res_data_reg, res_data_next;
    logic [POS_W-1:0]    res_found_reg,  res_found_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic signed [VAL_W-1:0] out_data_reg;
    logic [POS_W-1:0]    out_found_reg;
    logic [POS_W-1:0]    out_count_reg;
    logic                out_empty_reg;

    // store ports
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    // checks on the held request
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic                ins_bad;
    logic                rd_bad;
    logic                is_full;
    logic                ins_ok;
    logic [PW-1:0]       walk_len;
    logic                key_match;

    assign pos_ext   = PW'(pos_reg);
    assign cnt_ext   = PW'(count_reg);
    assign ins_bad   = (pos_reg == '0) || (pos_ext > cnt_ext + PW'(1));
    assign rd_bad    = (pos_reg == '0) || (pos_ext > cnt_ext);
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign ins_ok    = (cmd_reg == CMD_INSERT) && !ins_bad && !is_full;
    assign key_match = (ram_rd_data == key_reg);

    always_comb
    begin
        walk_len = '0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (ins_ok)
                begin
                    walk_len = cnt_ext - pos_ext + PW'(1);
                end
            end
            CMD_DELETE:
            begin
                if (!rd_bad)
                begin
                    walk_len = cnt_ext - pos_ext + PW'(1);
                end
            end
            CMD_GET:
            begin
                if (!rd_bad)
                begin
                    walk_len = PW'(1);
                end
            end
            CMD_LOCATE, CMD_PRIOR, CMD_NEXT:
            begin
                walk_len = cnt_ext;
            end
            default:
            begin
                walk_len = '0;
            end
        endcase
    end

    assign dp_sts.walk_req  = (walk_len != '0);
    assign dp_sts.key_req   = ins_ok;
    assign dp_sts.walk_done = (rd_left_reg == '0) && !rsp_vld_reg;
    assign dp_sts.out_free  = !out_valid_reg || !out_stall;

    // request capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg <= pal_cmd_t'(command);
            pos_reg <= position;
            key_reg <= DATA_WIDTH'(value);
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_left_next    = rd_left_reg;
        rsp_vld_next    = 1'b0;
        rsp_first_next  = rsp_first_reg;
        hit_next        = hit_reg;
        take_next_next  = take_next_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;

        if (dp_cmd.eval)
        begin
            res_data_next  = '0;
            res_found_next = '0;
            hit_next       = 1'b0;
            take_next_next = 1'b0;
            rsp_first_next = 1'b1;
            rd_left_next   = CW'(walk_len);
            rd_ptr_next    = '0;
            case (cmd_reg)
                CMD_INSERT:
                begin
                    rd_ptr_next = AW'(cnt_ext - PW'(1));
                    if (ins_bad)
                    begin
                        res_status_next = STS_BAD_POS;
                    end
                    else if (is_full)
                    begin
                        res_status_next = STS_FULL;
                    end
                    else
                    begin
                        res_status_next = STS_OK;
                    end
                end
                CMD_DELETE:
                begin
                    rd_ptr_next     = AW'(pos_ext - PW'(1));
                    res_status_next = rd_bad ? STS_BAD_POS : STS_OK;
                    if (!rd_bad)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_GET:
                begin
                    rd_ptr_next     = AW'(pos_ext - PW'(1));
                    res_status_next = rd_bad ? STS_BAD_POS : STS_OK;
                end
                CMD_LOCATE, CMD_PRIOR, CMD_NEXT:
                begin
                    res_status_next = STS_MISS;
                end
                CMD_CLEAR:
                begin
                    res_status_next = STS_OK;
                    count_next      = '0;
                end
                default:
                begin
                    res_status_next = STS_OK;
                end
            endcase
        end

        if (dp_cmd.walk)
        begin
            // issue the next read
            if (rd_left_reg != '0)
            begin
                ram_rd_en    = 1'b1;
                rsp_vld_next = 1'b1;
                rd_left_next = rd_left_reg - CW'(1);
                if (cmd_reg == CMD_INSERT)
                begin
                    rd_ptr_next = rd_ptr_reg - AW'(1);
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                end
            end
            // consume the read issued last cycle
            if (rsp_vld_reg)
            begin
                rsp_first_next = 1'b0;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = rsp_addr_reg + AW'(1);
                    end
                    CMD_DELETE:
                    begin
                        if (rsp_first_reg)
                        begin
                            res_data_next = VAL_W'($signed(ram_rd_data));
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = rsp_addr_reg - AW'(1);
                        end
                    end
                    CMD_GET:
                    begin
                        res_data_next = VAL_W'($signed(ram_rd_data));
                    end
                    CMD_LOCATE:
                    begin
                        if (!hit_reg && key_match)
                        begin
                            hit_next        = 1'b1;
                            res_status_next = STS_OK;
                            res_found_next  = POS_W'(CW'(rsp_addr_reg) + CW'(1));
                        end
                    end
                    CMD_PRIOR:
                    begin
                        if (!hit_reg && (rsp_addr_reg != '0) && key_match)
                        begin
                            hit_next        = 1'b1;
                            res_status_next = STS_OK;
                            res_data_next   = VAL_W'($signed(prev_data_reg));
                        end
                    end
                    CMD_NEXT:
                    begin
                        if (take_next_reg)
                        begin
                            take_next_next  = 1'b0;
                            hit_next        = 1'b1;
                            res_status_next = STS_OK;
                            res_data_next   = VAL_W'($signed(ram_rd_data));
                        end
                        else if (!hit_reg && key_match
                                 && ((CW'(rsp_addr_reg) + CW'(1)) < count_reg))
                        begin
                            take_next_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        ram_wr_en = 1'b0;
                    end
                endcase
            end
        end

        if (dp_cmd.put_key)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(pos_ext - PW'(1));
            ram_wr_data = key_reg;
            count_next  = count_reg + CW'(1);
        end

        if (dp_cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_left_reg   <= '0;
            rsp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            rsp_vld_reg   <= rsp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        rsp_first_reg  <= rsp_first_next;
        hit_reg        <= hit_next;
        take_next_reg  <= take_next_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        if (ram_rd_en)
        begin
            rsp_addr_reg <= rd_ptr_reg;
        end
        if (rsp_vld_reg)
        begin
            prev_data_reg <= ram_rd_data;
        end
        if (dp_cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= POS_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
        end
    end

    pal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign data_out       = out_data_reg;
    assign found_position = out_found_reg;
    assign count          = out_count_reg;
    assign is_empty       = out_empty_reg;

endmodule

// ===== sv/positional_array_list_top.sv =====
`timescale 1ns / 1ps
// Sequence: clear, rejected requests and the unused code go from evaluate straight to the
// result, an append at the tail writes the key without a walk, and get reads one entry. Insert,
// delete and the searches walk the store through its single read port, one entry a cycle,
// and a request may wait at the result while the previous result is still held.
// Throughput: one request at a time; the next is accepted the cycle after the result is registered.
// Reset clears the length and the output valid; store contents stay undefined.
// ----------------------------------------------------------------------------
// positional_array_list_top
// Ordered list of signed words in a fixed store with positional commands.
// ----------------------------------------------------------------------------
module positional_array_list_top #(
    parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pal_pkg::CMD_W-1:0]           command,
    input  logic [pal_pkg::POS_W-1:0]           position,
    input  logic signed [pal_pkg::VAL_W-1:0]    value,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pal_pkg::STATUS_W-1:0]        status,
    output logic signed [pal_pkg::VAL_W-1:0]    data_out,
    output logic [pal_pkg::POS_W-1:0]           found_position,
    output logic [pal_pkg::POS_W-1:0]           count,
    output logic                                is_empty
);

    import pal_pkg::*;

    // The controller steps each request through evaluate, an optional walk
    // over the store, an optional key write for insert, and the result
    // handoff. The datapath owns every register that carries data.
    pal_dp_cmd_t dp_cmd;
    pal_dp_sts_t dp_sts;

    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_cmd   (dp_cmd),
        .dp_sts   (dp_sts)
    );

    // Store, length counter, walk pointers and the result register. The
    // result register lets the next request come in while a result waits.
    pal_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .dp_sts         (dp_sts),
        .command        (command),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .data_out       (data_out),
        .found_position (found_position),
        .count          (count),
        .is_empty       (is_empty)
    );

endmodule
